[src/y86s_pkg.sv]
// y86s_pkg: shared types, codes and decode helpers for the y86 instruction step block
// used by the top level, the alu and the checker under src, no dependencies
package y86s_pkg;

    localparam int MEM_BYTES_DEF = 4096;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_MEMRD = 2'd2;
    localparam logic [1:0] OP_REGRD = 2'd3;

    localparam logic [1:0] ST_AOK = 2'd0;
    localparam logic [1:0] ST_HLT = 2'd1;
    localparam logic [1:0] ST_ADR = 2'd2;
    localparam logic [1:0] ST_INS = 2'd3;

    localparam logic [3:0] I_HALT  = 4'h0;
    localparam logic [3:0] I_NOP   = 4'h1;
    localparam logic [3:0] I_RRMOV = 4'h2;
    localparam logic [3:0] I_IRMOV = 4'h3;
    localparam logic [3:0] I_RMMOV = 4'h4;
    localparam logic [3:0] I_MRMOV = 4'h5;
    localparam logic [3:0] I_OPL   = 4'h6;
    localparam logic [3:0] I_JXX   = 4'h7;
    localparam logic [3:0] I_CALL  = 4'h8;
    localparam logic [3:0] I_RET   = 4'h9;
    localparam logic [3:0] I_PUSH  = 4'hA;
    localparam logic [3:0] I_POP   = 4'hB;
    localparam logic [3:0] R_NONE  = 4'hF;
    localparam logic [2:0] R_ESP   = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] address;
        logic [2:0]  reg_index;
        logic [7:0]  data;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pc;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
        logic [31:0] read_data;
    } t_out;

    typedef struct packed {
        logic z;
        logic s;
        logic o;
    } t_flags;

    typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_AND, ALU_XOR} t_alu_fn;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_F0, S_F1, S_F2, S_FI, S_FI2, S_EX, S_ADDR, S_OPB,
        S_SPDEC, S_POPCHK, S_POPFIN, S_POP2, S_LDREG, S_RDW, S_WRW,
        S_COMMIT, S_FIN
    } t_state;

    function automatic logic needs_reg(input logic [3:0] ic);
        logic r;
        r = (ic inside {[I_RRMOV:I_OPL], I_PUSH, I_POP});
        return r;
    endfunction

    function automatic logic needs_imm(input logic [3:0] ic);
        logic r;
        r = (ic inside {[I_IRMOV:I_MRMOV], I_JXX, I_CALL});
        return r;
    endfunction

    function automatic logic bad_enc(input logic [3:0] ic, input logic [3:0] fn,
                                     input logic [3:0] ra, input logic [3:0] rb);
        logic bad;
        case (ic)
            I_HALT, I_NOP:    bad = 1'b0;
            I_RRMOV:          bad = ra[3] || rb[3] || (fn > 4'd6);
            I_IRMOV:          bad = (fn != 4'd0) || (ra != R_NONE) || rb[3];
            I_RMMOV, I_MRMOV: bad = (fn != 4'd0) || ra[3] || rb[3];
            I_OPL:            bad = ra[3] || rb[3] || (fn > 4'd3);
            I_JXX, I_CALL:    bad = (fn > 4'd6);
            I_RET:            bad = (fn != 4'd0);
            I_PUSH, I_POP:    bad = (fn != 4'd0) || ra[3] || (rb != R_NONE);
            default:          bad = 1'b1;
        endcase
        return bad;
    endfunction

    function automatic logic cond_ok(input logic [3:0] fn, input t_flags f);
        logic lt;
        logic c;
        lt = f.s ^ f.o;
        case (fn)
            4'd0:    c = 1'b1;
            4'd1:    c = lt || f.z;
            4'd2:    c = lt;
            4'd3:    c = f.z;
            4'd4:    c = !f.z;
            4'd5:    c = !lt;
            default: c = !lt && !f.z;
        endcase
        return c;
    endfunction

endpackage

[src/y86_instruction_step_top.sv]
// y86_instruction_step_top: sequential y86 processor, sequencer around one shared alu
// depends on y86s_pkg, y86s_ram, y86s_alu
//
// input channel: i_in_valid / o_in_stall carry one item (op, address, reg_index, data).
// output channel: o_out_valid / i_out_stall carry one result item per input item.
// one item is worked on at a time; o_in_stall is high from acceptance until the
// result has been written to the output register.
// memory traffic goes through the byte ram port (one byte a cycle): an execute
// moves the fetch bytes, any immediate and, for memory, call, ret, push and
// pop, one data word.
// after reset the block clears MEM_BYTES ram bytes, one per cycle, and keeps
// o_in_stall high until that pass is done; registers, pc and flags reset at once.
// a stalled result holds in the output register; the next item can be accepted
// and worked on meanwhile, and it waits at its end until the output is free.
module y86_instruction_step_top #(
    parameter int MEM_BYTES = y86s_pkg::MEM_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  y86s_pkg::t_in  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output y86s_pkg::t_out o_out,
    input  logic           i_out_stall
);
    localparam int          AW        = $clog2(MEM_BYTES);
    localparam logic [31:0] MEM_LIM   = 32'(MEM_BYTES);
    localparam logic [31:0] LAST_WORD = 32'(MEM_BYTES - 4);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

    y86s_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [31:0]      r_rf [8];
    logic [31:0]      r_pc, n_pc, r_nx, n_nx, r_va, n_va, r_imm, n_imm, r_word, n_word;
    y86s_pkg::t_flags r_flags, n_flags;
    logic [AW-1:0]    r_ptr, n_ptr, r_clr, n_clr;
    logic [2:0]       r_cnt, n_cnt;
    logic [1:0]       r_st, n_st, r_op, n_op;
    logic [3:0]       r_icode, n_icode, r_ifun, n_ifun, r_ra, n_ra, r_rb, n_rb;
    y86s_pkg::t_out   r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;
    logic             rf_we;
    logic [2:0]       rf_wi;
    logic [31:0]      rf_wd;
    y86s_pkg::t_alu_fn alu_fn;
    logic [31:0]      alu_a, alu_b, alu_res;
    y86s_pkg::t_flags alu_flags;
    logic [31:0]      in_addr;

    function automatic logic fits(input logic [31:0] a);
        return a <= LAST_WORD;
    endfunction

    y86s_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    y86s_alu u_alu (
        .i_fn    (alu_fn),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    assign in_addr     = 32'(i_in.address);
    assign o_in_stall  = (r_state != y86s_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        alu_fn = y86s_pkg::ALU_ADD;
        alu_a  = r_nx;
        alu_b  = 32'd1;
        case (r_state)
            y86s_pkg::S_F0:     alu_a = r_pc;
            y86s_pkg::S_FI:     alu_b = 32'd4;
            y86s_pkg::S_ADDR: begin
                alu_a = r_va;
                alu_b = r_imm;
            end
            y86s_pkg::S_OPB: begin
                alu_fn = y86s_pkg::t_alu_fn'(r_ifun[1:0]);
                alu_a  = r_va;
                alu_b  = r_rf[r_rb[2:0]];
            end
            y86s_pkg::S_SPDEC: begin
                alu_fn = y86s_pkg::ALU_SUB;
                alu_a  = 32'd4;
                alu_b  = r_rf[y86s_pkg::R_ESP];
            end
            y86s_pkg::S_POPFIN: begin
                alu_a = r_va;
                alu_b = 32'd4;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pc    = r_pc;
        n_nx    = r_nx;
        n_va    = r_va;
        n_imm   = r_imm;
        n_word  = r_word;
        n_flags = r_flags;
        n_ptr   = r_ptr;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_st    = r_st;
        n_op    = r_op;
        n_icode = r_icode;
        n_ifun  = r_ifun;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_out   = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = r_word[7:0];
        ram_raddr = r_ptr;
        rf_we     = 1'b0;
        rf_wi     = r_rb[2:0];
        rf_wd     = alu_res;

        case (r_state)
            y86s_pkg::S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'd0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = y86s_pkg::S_IDLE;
                end
            end
            y86s_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in.op;
                    n_st    = y86s_pkg::ST_AOK;
                    n_state = y86s_pkg::S_FIN;
                    case (i_in.op)
                        y86s_pkg::OP_LOAD: begin
                            if (in_addr < MEM_LIM) begin
                                ram_we    = 1'b1;
                                ram_waddr = in_addr[AW-1:0];
                                ram_wdata = i_in.data;
                            end else begin
                                n_st = y86s_pkg::ST_ADR;
                            end
                        end
                        y86s_pkg::OP_EXEC: n_state = y86s_pkg::S_F0;
                        y86s_pkg::OP_MEMRD: begin
                            if (fits(in_addr)) begin
                                n_ptr   = in_addr[AW-1:0];
                                n_cnt   = 3'd0;
                                n_ret   = y86s_pkg::S_FIN;
                                n_state = y86s_pkg::S_RDW;
                            end else begin
                                n_st = y86s_pkg::ST_ADR;
                            end
                        end
                        default: n_word = r_rf[i_in.reg_index];
                    endcase
                end
            end
            y86s_pkg::S_F0: begin
                if (r_pc >= MEM_LIM) begin
                    n_st    = y86s_pkg::ST_ADR;
                    n_state = y86s_pkg::S_FIN;
                end else begin
                    ram_raddr = r_pc[AW-1:0];
                    n_nx      = alu_res;
                    n_state   = y86s_pkg::S_F1;
                end
            end
            y86s_pkg::S_F1: begin
                n_icode = ram_rdata[7:4];
                n_ifun  = ram_rdata[3:0];
                n_ra    = 4'd0;
                n_rb    = 4'd0;
                if (y86s_pkg::needs_reg(ram_rdata[7:4])) begin
                    if (r_nx >= MEM_LIM) begin
                        n_st    = y86s_pkg::ST_ADR;
                        n_state = y86s_pkg::S_FIN;
                    end else begin
                        ram_raddr = r_nx[AW-1:0];
                        n_nx      = alu_res;
                        n_state   = y86s_pkg::S_F2;
                    end
                end else if (y86s_pkg::needs_imm(ram_rdata[7:4])) begin
                    n_state = y86s_pkg::S_FI;
                end else begin
                    n_state = y86s_pkg::S_EX;
                end
            end
            y86s_pkg::S_F2: begin
                n_ra    = ram_rdata[7:4];
                n_rb    = ram_rdata[3:0];
                n_state = y86s_pkg::needs_imm(r_icode) ? y86s_pkg::S_FI : y86s_pkg::S_EX;
            end
            y86s_pkg::S_FI: begin
                if (!fits(r_nx)) begin
                    n_st    = y86s_pkg::ST_ADR;
                    n_state = y86s_pkg::S_FIN;
                end else begin
                    n_ptr   = r_nx[AW-1:0];
                    n_cnt   = 3'd0;
                    n_ret   = y86s_pkg::S_FI2;
                    n_nx    = alu_res;
                    n_state = y86s_pkg::S_RDW;
                end
            end
            y86s_pkg::S_FI2: begin
                n_imm   = r_word;
                n_state = y86s_pkg::S_EX;
            end
            y86s_pkg::S_EX: begin
                n_state = y86s_pkg::S_COMMIT;
                if (y86s_pkg::bad_enc(r_icode, r_ifun, r_ra, r_rb)) begin
                    n_st    = y86s_pkg::ST_INS;
                    n_state = y86s_pkg::S_FIN;
                end else begin
                    case (r_icode)
                        y86s_pkg::I_HALT: begin
                            n_st    = y86s_pkg::ST_HLT;
                            n_state = y86s_pkg::S_FIN;
                        end
                        y86s_pkg::I_RRMOV: begin
                            rf_we = y86s_pkg::cond_ok(r_ifun, r_flags);
                            rf_wd = r_rf[r_ra[2:0]];
                        end
                        y86s_pkg::I_IRMOV: begin
                            rf_we = 1'b1;
                            rf_wd = r_imm;
                        end
                        y86s_pkg::I_RMMOV, y86s_pkg::I_MRMOV: begin
                            n_va    = r_rf[r_rb[2:0]];
                            n_state = y86s_pkg::S_ADDR;
                        end
                        y86s_pkg::I_OPL: begin
                            n_va    = r_rf[r_ra[2:0]];
                            n_state = y86s_pkg::S_OPB;
                        end
                        y86s_pkg::I_JXX: begin
                            if (y86s_pkg::cond_ok(r_ifun, r_flags)) begin
                                n_nx = r_imm;
                            end
                        end
                        y86s_pkg::I_CALL: begin
                            if (y86s_pkg::cond_ok(r_ifun, r_flags)) begin
                                n_word  = r_nx;
                                n_state = y86s_pkg::S_SPDEC;
                            end
                        end
                        y86s_pkg::I_RET, y86s_pkg::I_POP: n_state = y86s_pkg::S_POPCHK;
                        y86s_pkg::I_PUSH: begin
                            n_word  = r_rf[r_ra[2:0]];
                            n_state = y86s_pkg::S_SPDEC;
                        end
                        default: ;
                    endcase
                end
            end
            y86s_pkg::S_ADDR: begin
                if (!fits(alu_res)) begin
                    n_st    = y86s_pkg::ST_ADR;
                    n_state = y86s_pkg::S_FIN;
                end else begin
                    n_ptr = alu_res[AW-1:0];
                    n_cnt = 3'd0;
                    if (r_icode == y86s_pkg::I_RMMOV) begin
                        n_word  = r_rf[r_ra[2:0]];
                        n_ret   = y86s_pkg::S_COMMIT;
                        n_state = y86s_pkg::S_WRW;
                    end else begin
                        n_ret   = y86s_pkg::S_LDREG;
                        n_state = y86s_pkg::S_RDW;
                    end
                end
            end
            y86s_pkg::S_LDREG: begin
                rf_we   = 1'b1;
                rf_wi   = r_ra[2:0];
                rf_wd   = r_word;
                n_state = y86s_pkg::S_COMMIT;
            end
            y86s_pkg::S_OPB: begin
                rf_we   = 1'b1;
                n_flags = alu_flags;
                n_state = y86s_pkg::S_COMMIT;
            end
            y86s_pkg::S_SPDEC: begin
                rf_we = 1'b1;
                rf_wi = y86s_pkg::R_ESP;
                if (!fits(alu_res)) begin
                    n_st    = y86s_pkg::ST_ADR;
                    n_state = y86s_pkg::S_FIN;
                end else begin
                    n_ptr   = alu_res[AW-1:0];
                    n_cnt   = 3'd0;
                    n_ret   = y86s_pkg::S_COMMIT;
                    n_state = y86s_pkg::S_WRW;
                    if (r_icode == y86s_pkg::I_CALL) begin
                        n_nx = r_imm;
                    end
                end
            end
            y86s_pkg::S_POPCHK: begin
                n_va = r_rf[y86s_pkg::R_ESP];
                if (!fits(r_rf[y86s_pkg::R_ESP])) begin
                    n_st    = y86s_pkg::ST_ADR;
                    n_state = y86s_pkg::S_FIN;
                end else begin
                    n_ptr   = r_rf[y86s_pkg::R_ESP][AW-1:0];
                    n_cnt   = 3'd0;
                    n_ret   = y86s_pkg::S_POPFIN;
                    n_state = y86s_pkg::S_RDW;
                end
            end
            y86s_pkg::S_POPFIN: begin
                rf_we = 1'b1;
                rf_wi = y86s_pkg::R_ESP;
                if (r_icode == y86s_pkg::I_RET) begin
                    n_nx    = r_word;
                    n_state = y86s_pkg::S_COMMIT;
                end else begin
                    n_state = y86s_pkg::S_POP2;
                end
            end
            y86s_pkg::S_POP2: begin
                rf_we   = 1'b1;
                rf_wi   = r_ra[2:0];
                rf_wd   = r_word;
                n_state = y86s_pkg::S_COMMIT;
            end
            y86s_pkg::S_RDW: begin
                n_ptr = r_ptr + 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt != 3'd0) begin
                    n_word = {ram_rdata, r_word[31:8]};
                end
                if (r_cnt == 3'd4) begin
                    n_state = r_ret;
                end
            end
            y86s_pkg::S_WRW: begin
                ram_we = 1'b1;
                n_word = {8'd0, r_word[31:8]};
                n_ptr  = r_ptr + 1'b1;
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_state = r_ret;
                end
            end
            y86s_pkg::S_COMMIT: begin
                n_pc    = r_nx;
                n_state = y86s_pkg::S_FIN;
            end
            y86s_pkg::S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status        = r_st;
                    n_out.pc            = r_pc;
                    n_out.zero_flag     = r_flags.z;
                    n_out.sign_flag     = r_flags.s;
                    n_out.overflow_flag = r_flags.o;
                    n_out.read_data     = ((r_st == y86s_pkg::ST_AOK) &&
                                           ((r_op == y86s_pkg::OP_MEMRD) ||
                                            (r_op == y86s_pkg::OP_REGRD))) ? r_word : 32'd0;
                    n_out_valid = 1'b1;
                    n_state     = y86s_pkg::S_IDLE;
                end
            end
            default: n_state = y86s_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= y86s_pkg::S_CLR;
            r_clr       <= '0;
            r_pc        <= 32'd0;
            r_flags     <= '{z: 1'b1, s: 1'b0, o: 1'b0};
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_rf[i] <= 32'd0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
            if (rf_we) begin
                r_rf[rf_wi] <= rf_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_nx    <= n_nx;
        r_va    <= n_va;
        r_imm   <= n_imm;
        r_word  <= n_word;
        r_ptr   <= n_ptr;
        r_cnt   <= n_cnt;
        r_st    <= n_st;
        r_op    <= n_op;
        r_icode <= n_icode;
        r_ifun  <= n_ifun;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_out   <= n_out;
    end
endmodule

[src/y86s_ram.sv]
// y86s_ram: generic single write, single read ram with registered read data
// depends on nothing
module y86s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/y86s_alu.sv]
// y86s_alu: shared 32-bit add, subtract, and, xor unit with condition flags
// depends on y86s_pkg
module y86s_alu (
    input  y86s_pkg::t_alu_fn i_fn,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output logic [31:0]       o_res,
    output y86s_pkg::t_flags  o_flags
);
    logic [31:0] res;
    logic        ov;

    always_comb begin
        ov = 1'b0;
        case (i_fn)
            y86s_pkg::ALU_ADD: begin
                res = i_a + i_b;
                ov  = (i_a[31] == i_b[31]) && (res[31] != i_b[31]);
            end
            y86s_pkg::ALU_SUB: begin
                res = i_b - i_a;
                ov  = (i_a[31] != i_b[31]) && (res[31] != i_b[31]);
            end
            y86s_pkg::ALU_AND: res = i_a & i_b;
            y86s_pkg::ALU_XOR: res = i_a ^ i_b;
            default:           res = i_a ^ i_b;
        endcase
    end

    assign o_res     = res;
    assign o_flags.z = (res == 32'd0);
    assign o_flags.s = res[31];
    assign o_flags.o = ov;
endmodule

[src/y86s_checker.sv]
// y86s_checker: port level checks for y86_instruction_step_top, bound to the top level
// depends on y86s_pkg and y86_instruction_step_top
module y86s_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input y86s_pkg::t_in  i_in,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input y86s_pkg::t_out o_out,
    input logic           i_out_stall
);
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result item changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous one still in work");

    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.read_data != 32'd0) |-> o_out.status == y86s_pkg::ST_AOK)
        else $error("read data on a faulted item");
endmodule

bind y86_instruction_step_top y86s_checker u_checker (.*);

[bench/tb_y86_instruction_step_top.sv]
// testbench for y86_instruction_step_top: directed and random y86 programs with a
// scoreboard that keeps its own copy of memory, registers, pc and flags
// depends on y86s_pkg and the block under src
module tb_y86_instruction_step_top;
    timeunit 1ns;
    timeprecision 1ps;
    import y86s_pkg::*;

    localparam int NBYTES = MEM_BYTES_DEF;
    localparam longint LIMIT = 3000000;

    class y86_scoreboard;
        logic [7:0]  mem [NBYTES];
        logic [31:0] rf [8];
        logic [31:0] pc;
        t_flags      fl;
        t_out        pending [$];
        int          errors;
        int          checked;
        int          halts;
        int          faults;

        function void clear();
            foreach (mem[i]) mem[i] = 8'h00;
            foreach (rf[i]) rf[i] = 32'h0;
            pc = 32'h0;
            fl = '{z: 1'b1, s: 1'b0, o: 1'b0};
            errors = 0;
            checked = 0;
            halts = 0;
            faults = 0;
        endfunction

        function bit fits(logic [31:0] a);
            return {32'h0, a} + 64'd4 <= NBYTES;
        endfunction

        function logic [31:0] rdw(logic [31:0] a);
            return {mem[a + 3], mem[a + 2], mem[a + 1], mem[a]};
        endfunction

        function void wrw(logic [31:0] a, logic [31:0] v);
            for (int i = 0; i < 4; i++) mem[a + i] = v[8 * i +: 8];
        endfunction

        function bit cond(logic [3:0] fn);
            bit lt;
            lt = fl.s != fl.o;
            case (fn)
                4'd0: return 1'b1;
                4'd1: return lt || fl.z;
                4'd2: return lt;
                4'd3: return fl.z;
                4'd4: return !fl.z;
                4'd5: return !lt;
                default: return !lt && !fl.z;
            endcase
        endfunction

        function logic [1:0] step_instruction();
            logic [31:0] nx, imm, a, b, v;
            logic [3:0]  ic, fn, ra, rb;
            bit          ov;
            nx = pc;
            ra = 0;
            rb = 0;
            imm = 0;
            if (nx >= NBYTES) return ST_ADR;
            {ic, fn} = mem[nx];
            nx++;
            if ((ic >= I_RRMOV && ic <= I_OPL) || ic == I_PUSH || ic == I_POP) begin
                if (nx >= NBYTES) return ST_ADR;
                {ra, rb} = mem[nx];
                nx++;
            end
            if ((ic >= I_IRMOV && ic <= I_MRMOV) || ic == I_JXX || ic == I_CALL) begin
                if (!fits(nx)) return ST_ADR;
                imm = rdw(nx);
                nx += 4;
            end
            case (ic)
                I_HALT: return ST_HLT;
                I_NOP: ;
                I_RRMOV: begin
                    if (ra > 7 || rb > 7 || fn > 6) return ST_INS;
                    if (cond(fn)) rf[rb[2:0]] = rf[ra[2:0]];
                end
                I_IRMOV: begin
                    if (fn != 0 || ra != R_NONE || rb > 7) return ST_INS;
                    rf[rb[2:0]] = imm;
                end
                I_RMMOV: begin
                    if (fn != 0 || ra > 7 || rb > 7) return ST_INS;
                    a = rf[rb[2:0]] + imm;
                    if (!fits(a)) return ST_ADR;
                    wrw(a, rf[ra[2:0]]);
                end
                I_MRMOV: begin
                    if (fn != 0 || ra > 7 || rb > 7) return ST_INS;
                    a = rf[rb[2:0]] + imm;
                    if (!fits(a)) return ST_ADR;
                    rf[ra[2:0]] = rdw(a);
                end
                I_OPL: begin
                    if (ra > 7 || rb > 7 || fn > 3) return ST_INS;
                    a = rf[ra[2:0]];
                    b = rf[rb[2:0]];
                    ov = 0;
                    case (fn)
                        4'd0: begin
                            v = a + b;
                            ov = (a[31] == b[31]) && (v[31] != b[31]);
                        end
                        4'd1: begin
                            v = b - a;
                            ov = (a[31] != b[31]) && (v[31] != b[31]);
                        end
                        4'd2: v = a & b;
                        default: v = a ^ b;
                    endcase
                    fl = '{z: (v == 0), s: v[31], o: ov};
                    rf[rb[2:0]] = v;
                end
                I_JXX: begin
                    if (fn > 6) return ST_INS;
                    if (cond(fn)) nx = imm;
                end
                I_CALL: begin
                    if (fn > 6) return ST_INS;
                    if (cond(fn)) begin
                        a = rf[R_ESP] - 4;
                        rf[R_ESP] = a;
                        if (!fits(a)) return ST_ADR;
                        wrw(a, nx);
                        nx = imm;
                    end
                end
                I_RET: begin
                    if (fn != 0) return ST_INS;
                    a = rf[R_ESP];
                    if (!fits(a)) return ST_ADR;
                    nx = rdw(a);
                    rf[R_ESP] = a + 4;
                end
                I_PUSH: begin
                    if (fn != 0 || ra > 7 || rb != R_NONE) return ST_INS;
                    v = rf[ra[2:0]];
                    a = rf[R_ESP] - 4;
                    rf[R_ESP] = a;
                    if (!fits(a)) return ST_ADR;
                    wrw(a, v);
                end
                I_POP: begin
                    if (fn != 0 || ra > 7 || rb != R_NONE) return ST_INS;
                    a = rf[R_ESP];
                    if (!fits(a)) return ST_ADR;
                    v = rdw(a);
                    rf[R_ESP] = a + 4;
                    rf[ra[2:0]] = v;
                end
                default: return ST_INS;
            endcase
            pc = nx;
            return ST_AOK;
        endfunction

        function void note_input(t_in it);
            t_out r;
            r = '0;
            case (it.op)
                OP_LOAD: mem[it.address] = it.data;
                OP_EXEC: r.status = step_instruction();
                OP_MEMRD: begin
                    if (fits(it.address)) r.read_data = rdw(it.address);
                    else r.status = ST_ADR;
                end
                default: r.read_data = rf[it.reg_index];
            endcase
            if (r.status == ST_HLT) halts++;
            if (r.status >= ST_ADR) faults++;
            r.pc = pc;
            r.zero_flag = fl.z;
            r.sign_flag = fl.s;
            r.overflow_flag = fl.o;
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out e;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected result", 0, got);
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status) report("status", e.status, got.status);
            if (got.pc != e.pc) report("pc", e.pc, got.pc);
            if (got.zero_flag != e.zero_flag) report("zero_flag", e.zero_flag, got.zero_flag);
            if (got.sign_flag != e.sign_flag) report("sign_flag", e.sign_flag, got.sign_flag);
            if (got.overflow_flag != e.overflow_flag)
                report("overflow_flag", e.overflow_flag, got.overflow_flag);
            if (got.read_data != e.read_data) report("read_data", e.read_data, got.read_data);
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
            errors++;
            if (errors <= 40)
                $display("mismatch %0d on %s: expected %h got %h", checked, what, exp_v, got_v);
        endfunction
    endclass

    logic i_clk, i_rst_n, i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    t_in  i_in;
    t_out o_out;

    y86_instruction_step_top dut (.*);

    y86_scoreboard sb;
    longint cycles;
    int     sent;
    bit     quiet;
    bit     hold_out;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // accepted items and delivered results, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_input(i_in);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
    end

    // receiver stalls, a long hold-off when asked
    initial begin
        int n;
        i_out_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1;
                repeat (400) @(negedge i_clk);
                hold_out = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 13);
                i_out_stall <= 1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    task automatic send(logic [1:0] op, logic [11:0] addr, logic [2:0] ri, logic [7:0] d);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            i_in_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= '{op: op, address: addr, reg_index: ri, data: d};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic put_byte(logic [11:0] a, logic [7:0] b);
        send(OP_LOAD, a, $urandom, b);
    endtask

    task automatic put_word(logic [11:0] a, logic [31:0] w);
        for (int i = 0; i < 4; i++) put_byte(a + i, w[8 * i +: 8]);
    endtask

    task automatic run_one();
        send(OP_EXEC, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // writes a random instruction at pc, mostly well formed
    task automatic plant_instruction(logic [31:0] at);
        logic [3:0]  ic, fn, ra, rb;
        logic [31:0] imm;
        int          len;
        ic = $urandom_range(0, 11);
        if ($urandom_range(0, 15) == 0) ic = $urandom;
        fn = (ic == I_JXX || ic == I_CALL || ic == I_RRMOV) ? $urandom_range(0, 6) :
             (ic == I_OPL) ? $urandom_range(0, 3) : 4'd0;
        if ($urandom_range(0, 19) == 0) fn = $urandom;
        ra = $urandom_range(0, 7);
        rb = $urandom_range(0, 7);
        if (ic == I_IRMOV) ra = R_NONE;
        if (ic == I_PUSH || ic == I_POP) rb = R_NONE;
        if ($urandom_range(0, 19) == 0) {ra, rb} = $urandom;
        case ($urandom_range(0, 5))
            0: imm = $urandom;
            1: imm = $urandom_range(NBYTES - 8, NBYTES + 4);
            default: imm = $urandom_range(0, 255) & ~32'h3;
        endcase
        if (ic == I_JXX || ic == I_CALL) imm = $urandom_range(0, 300);
        if ((ic == I_RMMOV || ic == I_MRMOV) && $urandom_range(0, 3) != 0)
            imm = $urandom_range(400, 800);
        len = 0;
        if (at + 6 > NBYTES) return;
        put_byte(at, {ic, fn});
        put_byte(at + 1, {ra, rb});
        put_word(at + 2, imm);
        if (ic >= I_IRMOV && ic <= I_MRMOV || ic == I_JXX || ic == I_CALL)
            if (!(ic >= I_RRMOV && ic <= I_OPL)) put_word(at + 1, imm);
    endtask

    initial begin
        sb = new();
        sb.clear();
        cycles = 0;
        sent = 0;
        quiet = 0;
        hold_out = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        // directed: edges of the fields, every op and fault
        send(OP_MEMRD, 12'hFFF, 3'd7, 8'hFF);
        send(OP_MEMRD, 12'hFFC, 3'd0, 8'h00);
        put_byte(12'hFFF, 8'hA5);
        send(OP_REGRD, 12'h000, 3'd7, 8'h00);
        run_one();                            // halt from cleared memory
        put_word(12'h000, 32'hFF30_1000);    // halt at 0, then an irmovl with a bad rb field
        put_word(12'h004, 32'h0000_0010);
        put_word(12'h008, 32'hFF00_A000);    // halt, then a pushl byte with eax and a bad rb field
        run_one();
        run_one();
        put_word(12'h010, 32'h3F30_FF80);    // irmovl, bad register field
        run_one();
        put_word(12'h010, 32'h0000_F090);    // ret, then garbage
        run_one();
        send(OP_REGRD, 12'h000, 3'd4, 8'h00);
        drain();

        // long receiver hold-off while items keep coming
        hold_out = 1;
        for (int i = 0; i < 40; i++) send(OP_REGRD, $urandom, $urandom, $urandom);

        // random: programs planted at the pc then run, plus raw loads and reads
        while (sent < 900) begin
            if (sent > 780) quiet = 1;
            case ($urandom_range(0, 9))
                0: send(OP_LOAD, $urandom, $urandom, $urandom);
                1: send(OP_MEMRD, $urandom, $urandom, $urandom);
                2: send(OP_REGRD, $urandom, $urandom, $urandom);
                default: begin
                    if (sb.pc >= NBYTES - 6 || sb.pending.size() != 0) begin
                        drain();
                        if (sb.pc >= NBYTES - 6 && $urandom_range(0, 1)) begin
                            run_one();
                        end else begin
                            put_word(sb.pc < NBYTES ? sb.pc[11:0] : 12'h0, 32'h0);
                        end
                        drain();
                    end
                    if (sb.pc < NBYTES - 6) begin
                        plant_instruction(sb.pc);
                        drain();
                        run_one();
                    end
                    if (sb.pc >= NBYTES) begin
                        // pc left memory: run one more step, which ends in an address fault
                        run_one();
                        drain();
                    end
                end
            endcase
            if (sb.pc >= NBYTES - 6 && sb.pending.size() == 0 && $urandom_range(0, 3) == 0)
                ;
        end
        drain();
        repeat (60) @(posedge i_clk);
        $display("%0d items sent, %0d results checked, %0d halts, %0d faults",
                 sent, sb.checked, sb.halts, sb.faults);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
